// ----- rtl/pto_pkg.sv -----
// ---------------------------------------------------------------------------
// pto_pkg
// Shared types, codes and constants of the peer table block.
// ---------------------------------------------------------------------------
package pto_pkg;

    localparam int PEER_SLOTS_DEF = 8;
    localparam int MAX_RESULTS    = 8;
    localparam int RES_CNT_W      = $clog2(MAX_RESULTS + 1);
    localparam int SLOT_W         = 3;
    localparam int MAC_W          = 48;
    localparam int WORD_W         = 32;
    localparam int CFG_IDX_W      = 1;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WORD_W-1:0] STALE_WIN_RST = 32'd3000;

    typedef enum logic
    {
        OP_UPDATE = 1'b0,
        OP_LIST   = 1'b1
    } op_e;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_SELF_IP   = 1'b0,
        CFG_STALE_WIN = 1'b1
    } cfg_idx_e;

    typedef struct packed
    {
        op_e                       op;
        logic [WORD_W-1:0]         now_ms;
        logic [MAC_W-1:0]          mac;
        logic [WORD_W-1:0]         ip;
        logic                      leader;
        logic signed [WORD_W-1:0]  group;
    } cmd_t;

    typedef struct packed
    {
        logic [MAC_W-1:0]          mac;
        logic [WORD_W-1:0]         ip;
        logic [WORD_W-1:0]         seen;
        logic                      leader;
        logic signed [WORD_W-1:0]  group;
    } entry_t;

    typedef struct packed
    {
        logic                      found;
        logic [SLOT_W-1:0]         slot;
        logic [MAC_W-1:0]          mac;
        logic [WORD_W-1:0]         ip;
        logic                      leader;
        logic signed [WORD_W-1:0]  group;
        logic [WORD_W-1:0]         age;
        logic                      last;
    } rec_t;

endpackage

// ----- rtl/pto_if.sv -----
// ---------------------------------------------------------------------------
// pto channel interfaces
// Command, response and configuration channels (valid/ready).
// ---------------------------------------------------------------------------
interface pto_cmd_if;
    import pto_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      opcode;
    logic [WORD_W-1:0]         now_ms;
    logic [MAC_W-1:0]          peer_mac;
    logic [WORD_W-1:0]         peer_ip;
    logic                      leader_flag;
    logic signed [WORD_W-1:0]  group_num;

    modport source (output valid, opcode, now_ms, peer_mac, peer_ip, leader_flag,
                    group_num, input ready);
    modport sink   (input valid, opcode, now_ms, peer_mac, peer_ip, leader_flag,
                    group_num, output ready);
endinterface

interface pto_rsp_if;
    import pto_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      found;
    logic [SLOT_W-1:0]         slot;
    logic [MAC_W-1:0]          out_mac;
    logic [WORD_W-1:0]         out_ip;
    logic                      out_leader;
    logic signed [WORD_W-1:0]  out_group;
    logic [WORD_W-1:0]         age_ms;
    logic                      last_of_run;

    modport source (output valid, found, slot, out_mac, out_ip, out_leader, out_group,
                    age_ms, last_of_run, input ready);
    modport sink   (input valid, found, slot, out_mac, out_ip, out_leader, out_group,
                    age_ms, last_of_run, output ready);
endinterface

interface pto_cfg_if;
    import pto_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [WORD_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/peer_table_oldest_replace_core.sv -----
// ---------------------------------------------------------------------------
// peer_table_oldest_replace_core
// Peer table with matching update, oldest-entry replacement and aged listing.
// ---------------------------------------------------------------------------
// An update or list command is picked from the two-beat command queue; the
// engine then makes one memory read per slot on the single table read port,
// checks the last slot read, and writes the entry or sends the closing
// response beat; an update that hits a stored MAC or IP ends its scan at that
// slot. A list response holds the scan while its output register waits on
// rsp.ready. The command queue keeps taking beats while the engine works,
// until it holds two. Configuration writes are taken every cycle.
module peer_table_oldest_replace_core
#(
    parameter int PEER_SLOTS = pto_pkg::PEER_SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    pto_cmd_if.sink     cmd,
    pto_rsp_if.source   rsp,
    pto_cfg_if.sink     cfg
);
    import pto_pkg::*;

    logic [WORD_W-1:0]  self_ip_reg, self_ip_next;
    logic [WORD_W-1:0]  stale_win_reg, stale_win_next;
    logic               q_valid;
    cmd_t               q_cmd;
    logic               q_pop;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        self_ip_next   = self_ip_reg;
        stale_win_next = stale_win_reg;
        if (cfg.valid)
        begin
            case (cfg_idx_e'(cfg.index))
                CFG_SELF_IP:   self_ip_next   = cfg.data;
                CFG_STALE_WIN: stale_win_next = cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_ip_reg   <= '0;
            stale_win_reg <= STALE_WIN_RST;
        end
        else
        begin
            self_ip_reg   <= self_ip_next;
            stale_win_reg <= stale_win_next;
        end
    end

    pto_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    pto_back
    #(
        .PEER_SLOTS (PEER_SLOTS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .self_ip   (self_ip_reg),
        .stale_win (stale_win_reg),
        .rsp       (rsp)
    );

endmodule

// ----- rtl/pto_front.sv -----
// ---------------------------------------------------------------------------
// pto_front
// Accepts command beats, classifies them and queues them for the engine.
// ---------------------------------------------------------------------------
module pto_front
(
    input  logic           clk,
    input  logic           rst_n,
    pto_cmd_if.sink        cmd,
    output logic           q_valid,
    output pto_pkg::cmd_t  q_cmd,
    input  logic           q_pop
);
    import pto_pkg::*;

    cmd_t               queue_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               push;
    logic               pop;
    cmd_t               in_cmd;

    assign cmd.ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign push      = cmd.valid && cmd.ready;
    assign q_valid   = (cnt_reg != '0);
    assign pop       = q_pop && q_valid;
    assign q_cmd     = queue_mem[rd_ptr_reg];

    always_comb
    begin
        in_cmd.op     = (cmd.opcode == 1'b1) ? OP_LIST : OP_UPDATE;
        in_cmd.now_ms = cmd.now_ms;
        in_cmd.mac    = cmd.peer_mac;
        in_cmd.ip     = cmd.peer_ip;
        in_cmd.leader = cmd.leader_flag;
        in_cmd.group  = cmd.group_num;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- rtl/pto_back.sv -----
// ---------------------------------------------------------------------------
// pto_back
// Table engine: scans the peer memory one entry per cycle barring a stall,
// replaces on update, streams qualifying list entries via an output register.
// ---------------------------------------------------------------------------
module pto_back
#(
    parameter int PEER_SLOTS = pto_pkg::PEER_SLOTS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  pto_pkg::cmd_t               q_cmd,
    output logic                        q_pop,
    input  logic [pto_pkg::WORD_W-1:0]  self_ip,
    input  logic [pto_pkg::WORD_W-1:0]  stale_win,
    pto_rsp_if.source                   rsp
);
    import pto_pkg::*;

    localparam int IDX_W = $clog2(PEER_SLOTS);
    localparam int CNT_W = $clog2(PEER_SLOTS + 1);

    typedef enum logic [3:0]
    {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_WRITE = 4'b0100,
        S_FLUSH = 4'b1000
    } state_e;

    entry_t                 entry_mem [PEER_SLOTS];
    logic [PEER_SLOTS-1:0]  vld_reg;

    state_e                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   ev_valid_reg, ev_valid_next;
    logic [IDX_W-1:0]       ev_idx_reg, ev_idx_next;
    entry_t                 rd_ent_reg;
    logic                   rd_vld_reg;
    logic [WORD_W-1:0]      min_seen_reg, min_seen_next;
    logic [IDX_W-1:0]       pick_reg, pick_next;
    logic                   pend_valid_reg, pend_valid_next;
    rec_t                   pend_reg, pend_next;
    logic [RES_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    rec_t                   rsp_rec_reg, rsp_rec_next;

    entry_t                 ev_ent;
    entry_t                 wr_ent;
    rec_t                   new_rec;
    rec_t                   emit_rec;
    logic [WORD_W-1:0]      age;
    logic                   is_list;
    logic                   hit;
    logic                   qual;
    logic                   ev_last;
    logic                   emit_ok;
    logic                   emit;
    logic                   stall;
    logic                   adv;
    logic                   rd_more;
    logic                   rd_en;
    logic                   mem_we;

    assign ev_ent   = rd_vld_reg ? rd_ent_reg : '0;
    assign age      = cmd_reg.now_ms - ev_ent.seen;
    assign is_list  = (cmd_reg.op == OP_LIST);
    assign hit      = (ev_ent.mac == cmd_reg.mac) || (ev_ent.ip == cmd_reg.ip);
    assign qual     = (age <= stale_win)
                      && !((self_ip != '0) && (ev_ent.ip == self_ip))
                      && (cnt_reg < RES_CNT_W'(MAX_RESULTS));
    assign ev_last  = (ev_idx_reg == IDX_W'(PEER_SLOTS - 1));
    assign emit_ok  = !rsp_valid_reg || rsp.ready;
    assign stall    = ev_valid_reg && is_list && qual && pend_valid_reg && !emit_ok;
    assign adv      = (state_reg == S_SCAN) && !stall;
    assign rd_more  = (rd_idx_reg < CNT_W'(PEER_SLOTS));
    assign rd_en    = adv && rd_more;

    always_comb
    begin
        wr_ent.mac    = cmd_reg.mac;
        wr_ent.ip     = cmd_reg.ip;
        wr_ent.seen   = cmd_reg.now_ms;
        wr_ent.leader = cmd_reg.leader;
        wr_ent.group  = cmd_reg.group;

        new_rec.found  = 1'b1;
        new_rec.slot   = SLOT_W'(ev_idx_reg);
        new_rec.mac    = ev_ent.mac;
        new_rec.ip     = ev_ent.ip;
        new_rec.leader = ev_ent.leader;
        new_rec.group  = ev_ent.group;
        new_rec.age    = age;
        new_rec.last   = 1'b0;
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        rd_idx_next     = rd_idx_reg;
        ev_valid_next   = ev_valid_reg;
        ev_idx_next     = ev_idx_reg;
        min_seen_next   = min_seen_reg;
        pick_next       = pick_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        cnt_next        = cnt_reg;
        q_pop           = 1'b0;
        emit            = 1'b0;
        emit_rec        = pend_reg;
        mem_we          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop           = 1'b1;
                    cmd_next        = q_cmd;
                    rd_idx_next     = '0;
                    ev_valid_next   = 1'b0;
                    pend_valid_next = 1'b0;
                    cnt_next        = '0;
                    pick_next       = '0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (adv)
                begin
                    ev_valid_next = rd_more;
                    if (rd_more)
                    begin
                        ev_idx_next = rd_idx_reg[IDX_W-1:0];
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                    if (ev_valid_reg)
                    begin
                        if (!is_list)
                        begin
                            if (hit)
                            begin
                                pick_next  = ev_idx_reg;
                                state_next = S_WRITE;
                            end
                            else
                            begin
                                if ((ev_idx_reg == '0) || (ev_ent.seen < min_seen_reg))
                                begin
                                    min_seen_next = ev_ent.seen;
                                    pick_next     = ev_idx_reg;
                                end
                                if (ev_last)
                                begin
                                    state_next = S_WRITE;
                                end
                            end
                        end
                        else
                        begin
                            if (qual)
                            begin
                                // previous record is known not to be the last one
                                emit            = pend_valid_reg;
                                pend_next       = new_rec;
                                pend_valid_next = 1'b1;
                                cnt_next        = cnt_reg + 1'b1;
                            end
                            if (ev_last)
                            begin
                                state_next = S_FLUSH;
                            end
                        end
                    end
                end
            end
            S_WRITE:
            begin
                mem_we     = 1'b1;
                state_next = S_IDLE;
            end
            S_FLUSH:
            begin
                if (emit_ok)
                begin
                    emit = 1'b1;
                    if (pend_valid_reg)
                    begin
                        emit_rec      = pend_reg;
                        emit_rec.last = 1'b1;
                    end
                    else
                    begin
                        emit_rec      = '0;
                        emit_rec.last = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_rec_next   = rsp_rec_reg;
        if (emit)
        begin
            rsp_valid_next = 1'b1;
            rsp_rec_next   = emit_rec;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // peer memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[pick_reg] <= wr_ent;
        end
        if (rd_en)
        begin
            rd_ent_reg <= entry_mem[rd_idx_reg[IDX_W-1:0]];
            rd_vld_reg <= vld_reg[rd_idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        ev_idx_reg   <= ev_idx_next;
        min_seen_reg <= min_seen_next;
        pick_reg     <= pick_next;
        pend_reg     <= pend_next;
        rsp_rec_reg  <= rsp_rec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            vld_reg        <= '0;
            rd_idx_reg     <= '0;
            ev_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_idx_reg     <= rd_idx_next;
            ev_valid_reg   <= ev_valid_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (mem_we)
            begin
                vld_reg[pick_reg] <= 1'b1;
            end
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.found       = rsp_rec_reg.found;
    assign rsp.slot        = rsp_rec_reg.slot;
    assign rsp.out_mac     = rsp_rec_reg.mac;
    assign rsp.out_ip      = rsp_rec_reg.ip;
    assign rsp.out_leader  = rsp_rec_reg.leader;
    assign rsp.out_group   = rsp_rec_reg.group;
    assign rsp.age_ms      = rsp_rec_reg.age;
    assign rsp.last_of_run = rsp_rec_reg.last;

endmodule

// ----- rtl/pto_checker.sv -----
// ---------------------------------------------------------------------------
// pto_checker
// Port-level checks on the response channel of the peer table.
// ---------------------------------------------------------------------------
module pto_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rsp_valid,
    input  logic                        rsp_ready,
    input  logic                        rsp_found,
    input  logic [pto_pkg::SLOT_W-1:0]  rsp_slot,
    input  logic [pto_pkg::WORD_W-1:0]  rsp_ip,
    input  logic [pto_pkg::WORD_W-1:0]  rsp_age,
    input  logic                        rsp_last
);

    ap_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response beat dropped while stalled");

    ap_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_found) && $stable(rsp_slot)
                                    && $stable(rsp_age) && $stable(rsp_last))
        else $error("response payload changed while stalled");

    ap_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_found |-> rsp_last && (rsp_slot == '0) && (rsp_ip == '0)
                                    && (rsp_age == '0))
        else $error("empty marker malformed");

    ap_mid_is_record: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_last |-> rsp_found)
        else $error("non-final beat is not a peer record");

endmodule

bind peer_table_oldest_replace_core pto_checker u_pto_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_found (rsp.found),
    .rsp_slot  (rsp.slot),
    .rsp_ip    (rsp.out_ip),
    .rsp_age   (rsp.age_ms),
    .rsp_last  (rsp.last_of_run)
);
